// ----- hw/rtl/lfsc_pkg.sv -----
// Shared types and constants for the line follower sensor controller.
`timescale 1ns / 1ps
`default_nettype none
package lfsc_pkg;

  localparam int unsigned NumSensors = 6;

  typedef enum logic [1:0] {
    REG_SENSOR_SETTLE = 2'd0,
    REG_CLASS_SETTLE  = 2'd1,
    REG_STOP_SETTLE   = 2'd2,
    REG_BLINK_PERIOD  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_FORWARD = 2'd1,
    CLASS_LEFT    = 2'd2,
    CLASS_RIGHT   = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    DRIVE_STOP        = 2'd0,
    DRIVE_FORWARD     = 2'd1,
    DRIVE_PIVOT_LEFT  = 2'd2,
    DRIVE_PIVOT_RIGHT = 2'd3
  } drive_e;

  typedef enum logic [2:0] {
    DISP_FORWARD     = 3'd0,
    DISP_PIVOT_LEFT  = 3'd1,
    DISP_PIVOT_RIGHT = 3'd2,
    DISP_STOPPED     = 3'd3,
    DISP_SEARCHING   = 3'd4
  } disp_e;

  typedef struct packed {
    logic [7:0]  sensor_settle;
    logic [7:0]  class_settle;
    logic [9:0]  stop_settle;
    logic [15:0] blink_period;
  } cfg_t;

  typedef struct packed {
    drive_e drive;
    logic   boost;
    logic   led;
    disp_e  disp;
  } res_t;

  localparam logic [7:0]  SensorSettleRst = 8'd5;
  localparam logic [7:0]  ClassSettleRst  = 8'd10;
  localparam logic [9:0]  StopSettleRst   = 10'd100;
  localparam logic [15:0] BlinkPeriodRst  = 16'd25000;
  localparam logic [1:0]  BoostLast       = 2'd2;

  function automatic disp_e class_to_disp(class_e c);
    disp_e d;
    case (c)
      CLASS_FORWARD: d = DISP_FORWARD;
      CLASS_LEFT:    d = DISP_PIVOT_LEFT;
      CLASS_RIGHT:   d = DISP_PIVOT_RIGHT;
      default:       d = DISP_SEARCHING;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lfsc_sensor_filter.sv -----
// Per-sensor debounce lanes holding the committed sensor levels.
`timescale 1ns / 1ps
`default_nettype none
module lfsc_sensor_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic [lfsc_pkg::NumSensors-1:0] raw_i,
  input  wire logic [7:0]                     settle_i,
  output logic [lfsc_pkg::NumSensors-1:0]     sens_o
);

  logic [lfsc_pkg::NumSensors-1:0] sens_q, sens_d;
  logic [7:0] cnt_q [lfsc_pkg::NumSensors];
  logic [7:0] cnt_d [lfsc_pkg::NumSensors];

  always_comb begin
    for (int i = 0; i < lfsc_pkg::NumSensors; i++) begin
      sens_d[i] = sens_q[i];
      cnt_d[i]  = 8'd0;
      if (raw_i[i] != sens_q[i]) begin
        if (cnt_q[i] >= settle_i) begin
          sens_d[i] = raw_i[i];
        end else if (cnt_q[i] != 8'hFF) begin
          cnt_d[i] = cnt_q[i] + 8'd1;
        end else begin
          cnt_d[i] = cnt_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= '0;
      for (int i = 0; i < lfsc_pkg::NumSensors; i++) cnt_q[i] <= 8'd0;
    end else if (en_i) begin
      sens_q <= sens_d;
      for (int i = 0; i < lfsc_pkg::NumSensors; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  assign sens_o = sens_d;

endmodule
`default_nettype wire

// ----- hw/rtl/lfsc_motion_ctrl.sv -----
// Motion class debounce, stop detection, LED blink and boost phase.
`timescale 1ns / 1ps
`default_nettype none
module lfsc_motion_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic [lfsc_pkg::NumSensors-1:0] sens_i,
  input  wire lfsc_pkg::cfg_t                 cfg_i,
  output lfsc_pkg::res_t                      res_o
);

  lfsc_pkg::class_e committed_q, committed_d, last_q, last_d, active_q, active_d, cand;
  logic [7:0]  cls_cnt_q, cls_cnt_d;
  logic [9:0]  low_cnt_q, low_cnt_d;
  logic [15:0] blink_cnt_q, blink_cnt_d, blink_inc;
  logic        phase_q, phase_d, led_q, led_d;
  logic [1:0]  boost_q, boost_d;
  logic        left, mid, right, all_hi, all_lo, normal, stop;

  always_comb begin
    left   = |sens_i[1:0];
    mid    = |sens_i[3:2];
    right  = |sens_i[5:4];
    all_hi = left & mid & right;
    all_lo = ~(left | mid | right);
    normal = ~all_hi & ~all_lo;

    committed_d = committed_q;
    last_d      = last_q;
    active_d    = active_q;
    cls_cnt_d   = cls_cnt_q;
    low_cnt_d   = low_cnt_q;
    stop        = 1'b0;
    cand        = lfsc_pkg::CLASS_FORWARD;

    if (all_hi) begin
      low_cnt_d = 10'd0;
      active_d  = lfsc_pkg::CLASS_FORWARD;
    end else if (all_lo) begin
      stop = (low_cnt_q >= cfg_i.stop_settle);
      if (low_cnt_q != 10'h3FF) low_cnt_d = low_cnt_q + 10'd1;
    end else begin
      low_cnt_d = 10'd0;
      if (mid) cand = lfsc_pkg::CLASS_FORWARD;
      else if (left && !right) cand = lfsc_pkg::CLASS_LEFT;
      else if (right && !left) cand = lfsc_pkg::CLASS_RIGHT;
      else cand = lfsc_pkg::CLASS_FORWARD;
      if (cand != committed_q) begin
        if (cls_cnt_q >= cfg_i.class_settle) begin
          committed_d = cand;
          cls_cnt_d   = 8'd0;
        end else if (cls_cnt_q != 8'hFF) begin
          cls_cnt_d = cls_cnt_q + 8'd1;
        end
      end else begin
        cls_cnt_d = 8'd0;
      end
      active_d = committed_d;
      if (committed_d != lfsc_pkg::CLASS_NONE) last_d = committed_d;
    end
  end

  always_comb begin
    blink_inc   = (blink_cnt_q == 16'hFFFF) ? blink_cnt_q : blink_cnt_q + 16'd1;
    blink_cnt_d = blink_inc;
    phase_d     = phase_q;
    led_d       = led_q;
    if (normal) begin
      if (blink_inc >= cfg_i.blink_period) begin
        blink_cnt_d = 16'd0;
        phase_d     = ~phase_q;
        led_d       = ~phase_q;
      end
    end else begin
      blink_cnt_d = 16'd0;
      phase_d     = 1'b0;
      led_d       = 1'b1;
    end
    boost_d = (boost_q >= lfsc_pkg::BoostLast) ? 2'd0 : boost_q + 2'd1;
  end

  always_comb begin
    if (stop) begin
      res_o.drive = lfsc_pkg::DRIVE_STOP;
      res_o.disp  = lfsc_pkg::DISP_STOPPED;
    end else if (all_hi) begin
      res_o.drive = lfsc_pkg::DRIVE_FORWARD;
      res_o.disp  = lfsc_pkg::DISP_FORWARD;
    end else if (active_d != lfsc_pkg::CLASS_NONE) begin
      res_o.drive = lfsc_pkg::drive_e'(active_d);
      res_o.disp  = lfsc_pkg::class_to_disp(active_d);
    end else begin
      res_o.drive = lfsc_pkg::drive_e'(last_d);
      res_o.disp  = lfsc_pkg::DISP_SEARCHING;
    end
    res_o.boost = (res_o.drive == lfsc_pkg::DRIVE_FORWARD) && (boost_d == 2'd1);
    res_o.led   = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= lfsc_pkg::CLASS_NONE;
      last_q      <= lfsc_pkg::CLASS_FORWARD;
      active_q    <= lfsc_pkg::CLASS_NONE;
      cls_cnt_q   <= 8'd0;
      low_cnt_q   <= 10'd0;
      blink_cnt_q <= 16'd0;
      phase_q     <= 1'b0;
      led_q       <= 1'b1;
      boost_q     <= 2'd0;
    end else if (en_i) begin
      committed_q <= committed_d;
      last_q      <= last_d;
      active_q    <= active_d;
      cls_cnt_q   <= cls_cnt_d;
      low_cnt_q   <= low_cnt_d;
      blink_cnt_q <= blink_cnt_d;
      phase_q     <= phase_d;
      led_q       <= led_d;
      boost_q     <= boost_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/line_follower_sensor_controller_unit.sv -----
// Top level of the line follower sensor controller.
// One transfer on the input channel is one tick: six raw line sensors.
// Each tick yields exactly one result transfer: drive mode, forward boost,
// LED level and display code, in tick order.
// The input channel is registered; the tick is then evaluated in one pass of
// combinational logic into the result register, from which the result is
// offered on the output channel.
// Throughput is one tick per cycle while the receiver does not stall, set by
// the state update of the debounce and class logic.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; further input is stalled until the result moves.
// The config channel writes one of four threshold registers; it is always
// ready and must only be written while no tick is in flight.
// Reset (async, active low) restores the thresholds to 5, 10, 100 and 25000,
// clears all debounce state, lights the LED and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module line_follower_sensor_controller_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [5:0] raw_sensors_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      drive_mode_o,
  output logic            forward_boost_o,
  output logic            led_lit_o,
  output logic [2:0]      display_code_o
);

  lfsc_pkg::cfg_t cfg_q;
  lfsc_pkg::res_t res_d, res_q;
  logic [5:0] raw_q;
  logic       s1_vld_q, out_vld_q, s2_ready, fire2, in_fire;
  logic [lfsc_pkg::NumSensors-1:0] sens;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_settle <= lfsc_pkg::SensorSettleRst;
      cfg_q.class_settle  <= lfsc_pkg::ClassSettleRst;
      cfg_q.stop_settle   <= lfsc_pkg::StopSettleRst;
      cfg_q.blink_period  <= lfsc_pkg::BlinkPeriodRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lfsc_pkg::reg_idx_e'(cfg_index_i))
        lfsc_pkg::REG_SENSOR_SETTLE: cfg_q.sensor_settle <= cfg_data_i[7:0];
        lfsc_pkg::REG_CLASS_SETTLE:  cfg_q.class_settle  <= cfg_data_i[7:0];
        lfsc_pkg::REG_STOP_SETTLE:   cfg_q.stop_settle   <= cfg_data_i[9:0];
        lfsc_pkg::REG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s2_ready   = ~out_vld_q | ~out_stall_i;
  assign fire2      = s1_vld_q & s2_ready;
  assign in_stall_o = s1_vld_q & ~s2_ready;
  assign in_fire    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) s1_vld_q <= 1'b1;
      else if (fire2) s1_vld_q <= 1'b0;
      if (fire2) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) raw_q <= raw_sensors_i;
    if (fire2) res_q <= res_d;
  end

  lfsc_sensor_filter u_sensor_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fire2),
    .raw_i    (raw_q),
    .settle_i (cfg_q.sensor_settle),
    .sens_o   (sens)
  );

  lfsc_motion_ctrl u_motion_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire2),
    .sens_i (sens),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o     = out_vld_q;
  assign drive_mode_o    = res_q.drive;
  assign forward_boost_o = res_q.boost;
  assign led_lit_o       = res_q.led;
  assign display_code_o  = res_q.disp;

  a_stop_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.drive == lfsc_pkg::DRIVE_STOP) ==
                   (res_q.disp == lfsc_pkg::DISP_STOPPED)))
    else $error("stop drive and stopped display disagree");

  a_boost_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.boost) |-> (res_q.drive == lfsc_pkg::DRIVE_FORWARD))
    else $error("boost outside forward drive");

  a_boost_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 && res_d.boost |=> !(fire2 && res_d.boost))
    else $error("boost on consecutive ticks");

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s2_ready) |=> s1_vld_q)
    else $error("stalled tick dropped from input register");

  a_disp_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.disp == lfsc_pkg::DISP_PIVOT_LEFT) |->
      (res_q.drive == lfsc_pkg::DRIVE_PIVOT_LEFT))
    else $error("pivot left display without pivot left drive");

endmodule
`default_nettype wire
